// ===== rtl/core/tta_pkg.sv =====
package tta_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_RISING   = 5'b00010,
        MODE_LOWERING = 5'b00100,
        MODE_UP       = 5'b01000,
        MODE_DOWN     = 5'b10000
    } mode_t;

    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_RISING   = 3'd1;
    localparam logic [2:0] CODE_LOWERING = 3'd2;
    localparam logic [2:0] CODE_UP       = 3'd3;
    localparam logic [2:0] CODE_DOWN     = 3'd4;

    localparam logic CFG_RAISE_TIME = 1'b0;
    localparam logic CFG_LOWER_TIME = 1'b1;

    localparam logic [19:0] RAISE_TIME_RESET = 20'd3000;
    localparam logic [19:0] LOWER_TIME_RESET = 20'd3000;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        begin
            unique case (m)
                MODE_RISING:   c = CODE_RISING;
                MODE_LOWERING: c = CODE_LOWERING;
                MODE_UP:       c = CODE_UP;
                MODE_DOWN:     c = CODE_DOWN;
                default:       c = CODE_IDLE;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== rtl/core/tta_blink.sv =====
module tta_blink #(
    parameter int BLINK_PERIOD = 400
) (
    input  logic        clk,
    input  logic        advance,
    input  logic [31:0] now_ms,
    output logic        phase
);

    localparam logic [15:0] PERIOD = 16'(BLINK_PERIOD);
    // Reciprocal of the period, rounded down; the estimated quotient is exact or one low.
    localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / BLINK_PERIOD);

    logic [31:0] quot_reg;
    logic [17:0] now_low_reg;
    logic [63:0] prod;
    logic [33:0] back_prod;
    logic [17:0] rem;
    logic        rem_over;

    assign prod = now_ms * RECIP;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quot_reg    <= prod[63:32];
            now_low_reg <= now_ms[17:0];
        end
    end

    // The remainder stays below twice the period, so 18 low bits carry it exactly.
    assign back_prod = quot_reg[17:0] * PERIOD;
    assign rem       = now_low_reg - back_prod[17:0];
    assign rem_over  = (rem >= {2'b00, PERIOD});
    assign phase     = ~(quot_reg[0] ^ rem_over);

endmodule

// ===== rtl/core/timed_two_way_actuator_control.sv =====
// A beat passes the s1 and s2 registers; the mode update then loads the output stage.
// Throughput: one beat per cycle while out_stall does not hold the pipeline; the blink
// phase divider has a registered reciprocal multiply stage ahead of the mode update.
// Reset (rst_n, asynchronous, active low): mode idle, count zero, both LEDs on,
// remembered button levels and activity off, travel times 3000 ms, pipeline empty.
module timed_two_way_actuator_control #(
    parameter int BLINK_PERIOD = 400
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] elapsed_ms,
    input  logic [31:0] now_ms,
    input  logic        up_held,
    input  logic        down_held,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        valve_up,
    output logic        valve_down,
    output logic        led_up,
    output logic        led_down,
    output logic        activity_led,
    output logic [2:0]  mode_now
);

    logic [19:0] raise_time_reg;
    logic [19:0] lower_time_reg;

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        out_valid_reg;
    logic        advance;

    logic [15:0] s1_elapsed_reg;
    logic [31:0] s1_now_reg;
    logic        s1_up_reg;
    logic        s1_down_reg;
    logic [15:0] s2_elapsed_reg;
    logic        s2_up_reg;
    logic        s2_down_reg;
    logic        phase;

    tta_pkg::mode_t     mode_reg, mode_next;
    logic signed [20:0] time_left_reg, time_left_next;
    logic               prev_up_reg, prev_up_next;
    logic               prev_down_reg, prev_down_next;
    logic               led_up_reg, led_up_next;
    logic               led_down_reg, led_down_next;
    logic               activity_reg, activity_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raise_time_reg <= tta_pkg::RAISE_TIME_RESET;
            lower_time_reg <= tta_pkg::LOWER_TIME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tta_pkg::CFG_RAISE_TIME: raise_time_reg <= cfg_data;
                tta_pkg::CFG_LOWER_TIME: lower_time_reg <= cfg_data;
                default:                 raise_time_reg <= raise_time_reg;
            endcase
        end
    end

    // The whole pipeline moves together unless a finished result is held back.
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_elapsed_reg <= elapsed_ms;
            s1_now_reg     <= now_ms;
            s1_up_reg      <= up_held;
            s1_down_reg    <= down_held;
            s2_elapsed_reg <= s1_elapsed_reg;
            s2_up_reg      <= s1_up_reg;
            s2_down_reg    <= s1_down_reg;
        end
    end

    tta_blink #(
        .BLINK_PERIOD(BLINK_PERIOD)
    ) u_blink (
        .clk     (clk),
        .advance (advance),
        .now_ms  (s1_now_reg),
        .phase   (phase)
    );

    always_comb
    begin
        logic               rel_up;
        logic               rel_down;
        logic               enter;
        tta_pkg::mode_t     target;
        logic signed [20:0] count;

        mode_next      = mode_reg;
        time_left_next = time_left_reg;
        prev_up_next   = prev_up_reg;
        prev_down_next = prev_down_reg;
        led_up_next    = led_up_reg;
        led_down_next  = led_down_reg;
        activity_next  = activity_reg;
        enter          = 1'b0;
        target         = tta_pkg::MODE_IDLE;

        rel_up   = prev_up_reg && !s2_up_reg;
        rel_down = prev_down_reg && !s2_down_reg;
        count    = time_left_reg - $signed({5'b00000, s2_elapsed_reg});

        unique case (mode_reg)
            tta_pkg::MODE_RISING, tta_pkg::MODE_LOWERING:
            begin
                if (mode_reg == tta_pkg::MODE_RISING)
                    led_up_next = phase;
                else
                    led_down_next = phase;
                time_left_next = count;
                prev_up_next   = s2_up_reg;
                activity_next  = s2_up_reg;
                if (rel_up)
                begin
                    enter = 1'b1;
                end
                else
                begin
                    prev_down_next = s2_down_reg;
                    activity_next  = s2_down_reg;
                    if (rel_down)
                    begin
                        enter = 1'b1;
                    end
                    else if (count[20] || (count == 21'sd0))
                    begin
                        enter  = 1'b1;
                        target = (mode_reg == tta_pkg::MODE_RISING) ?
                                 tta_pkg::MODE_UP : tta_pkg::MODE_DOWN;
                    end
                end
            end
            tta_pkg::MODE_UP:
            begin
                prev_down_next = s2_down_reg;
                activity_next  = s2_down_reg;
                if (rel_down)
                begin
                    enter  = 1'b1;
                    target = tta_pkg::MODE_LOWERING;
                end
            end
            tta_pkg::MODE_DOWN:
            begin
                prev_up_next  = s2_up_reg;
                activity_next = s2_up_reg;
                if (rel_up)
                begin
                    enter  = 1'b1;
                    target = tta_pkg::MODE_RISING;
                end
            end
            default:
            begin
                prev_up_next  = s2_up_reg;
                activity_next = s2_up_reg;
                if (rel_up)
                begin
                    enter  = 1'b1;
                    target = tta_pkg::MODE_RISING;
                end
                else
                begin
                    prev_down_next = s2_down_reg;
                    activity_next  = s2_down_reg;
                    if (rel_down)
                    begin
                        enter  = 1'b1;
                        target = tta_pkg::MODE_LOWERING;
                    end
                end
            end
        endcase

        // Entering a mode overrides the blink level set above.
        if (enter)
        begin
            mode_next = target;
            unique case (target)
                tta_pkg::MODE_RISING:
                begin
                    led_down_next  = 1'b0;
                    time_left_next = $signed({1'b0, raise_time_reg});
                end
                tta_pkg::MODE_LOWERING:
                begin
                    led_up_next    = 1'b0;
                    time_left_next = $signed({1'b0, lower_time_reg});
                end
                tta_pkg::MODE_UP:
                begin
                    led_up_next   = 1'b1;
                    led_down_next = 1'b0;
                end
                tta_pkg::MODE_DOWN:
                begin
                    led_up_next   = 1'b0;
                    led_down_next = 1'b1;
                end
                default:
                begin
                    led_up_next    = 1'b1;
                    led_down_next  = 1'b1;
                    time_left_next = 21'sd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tta_pkg::MODE_IDLE;
            time_left_reg <= 21'sd0;
            prev_up_reg   <= 1'b0;
            prev_down_reg <= 1'b0;
            led_up_reg    <= 1'b1;
            led_down_reg  <= 1'b1;
            activity_reg  <= 1'b0;
        end
        else if (advance && s2_valid_reg)
        begin
            mode_reg      <= mode_next;
            time_left_reg <= time_left_next;
            prev_up_reg   <= prev_up_next;
            prev_down_reg <= prev_down_next;
            led_up_reg    <= led_up_next;
            led_down_reg  <= led_down_next;
            activity_reg  <= activity_next;
        end
    end

    // The state registers load exactly when a result enters the output stage.
    assign out_valid    = out_valid_reg;
    assign valve_up     = (mode_reg == tta_pkg::MODE_RISING);
    assign valve_down   = (mode_reg == tta_pkg::MODE_LOWERING);
    assign led_up       = led_up_reg;
    assign led_down     = led_down_reg;
    assign activity_led = activity_reg;
    assign mode_now     = tta_pkg::mode_code(mode_reg);

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tta_pkg::MODE_IDLE) |-> (time_left_reg == 21'sd0))
        else $error("count is not zero in idle mode");

    a_rising_led_down_off: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == tta_pkg::MODE_RISING) |-> !led_down_reg)
        else $error("down LED lit while rising");

    a_state_holds_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s2_valid_reg) |=> ($stable(mode_reg) && $stable(time_left_reg)))
        else $error("state changed without a beat");

    a_accept_fills_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost at the input stage");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic [31:0] BLINK_MS = 32'd400;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic       valve_up;
        logic       valve_down;
        logic       led_up;
        logic       led_down;
        logic       activity;
        logic [2:0] mode;
    } tick_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = tta_pkg::CFG_RAISE_TIME;
    logic [19:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] elapsed_ms = '0;
    logic [31:0] now_ms = '0;
    logic        up_held = 1'b0;
    logic        down_held = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valve_up;
    logic        valve_down;
    logic        led_up;
    logic        led_down;
    logic        activity_led;
    logic [2:0]  mode_now;

    // Predicted actuator state.
    logic [2:0]  pred_mode;
    int          pred_count;
    logic        pred_prev_up;
    logic        pred_prev_down;
    logic        pred_led_up;
    logic        pred_led_down;
    logic        pred_activity;
    logic [19:0] pred_raise_ms;
    logic [19:0] pred_lower_ms;

    tick_result_t pending_ticks[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          ticks_sent = 0;
    int          hold_off_left = 0;
    int          stall_run = 0;
    bit          idle_gaps_on = 1'b1;
    bit          stall_gaps_on = 1'b1;
    logic [31:0] wall_ms = '0;

    timed_two_way_actuator_control #(
        .BLINK_PERIOD(BLINK_MS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .elapsed_ms(elapsed_ms),
        .now_ms(now_ms),
        .up_held(up_held),
        .down_held(down_held),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .valve_up(valve_up),
        .valve_down(valve_down),
        .led_up(led_up),
        .led_down(led_down),
        .activity_led(activity_led),
        .mode_now(mode_now)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void reset_prediction();
        pred_mode = tta_pkg::CODE_IDLE;
        pred_count = 0;
        pred_prev_up = 1'b0;
        pred_prev_down = 1'b0;
        pred_led_up = 1'b1;
        pred_led_down = 1'b1;
        pred_activity = 1'b0;
        pred_raise_ms = tta_pkg::RAISE_TIME_RESET;
        pred_lower_ms = tta_pkg::LOWER_TIME_RESET;
    endfunction

    // A press counts when the remembered level was high and the new one is low.
    function automatic bit up_released(input logic level);
        bit rel;
        rel = pred_prev_up && !level;
        pred_prev_up = level;
        pred_activity = level;
        return rel;
    endfunction

    function automatic bit down_released(input logic level);
        bit rel;
        rel = pred_prev_down && !level;
        pred_prev_down = level;
        pred_activity = level;
        return rel;
    endfunction

    function automatic void enter_mode(input logic [2:0] next_mode);
        case (next_mode)
            tta_pkg::CODE_RISING:
            begin
                pred_led_down = 1'b0;
                pred_count = int'(pred_raise_ms);
                pred_mode = tta_pkg::CODE_RISING;
            end
            tta_pkg::CODE_LOWERING:
            begin
                pred_led_up = 1'b0;
                pred_count = int'(pred_lower_ms);
                pred_mode = tta_pkg::CODE_LOWERING;
            end
            tta_pkg::CODE_UP:
            begin
                pred_led_up = 1'b1;
                pred_led_down = 1'b0;
                pred_mode = tta_pkg::CODE_UP;
            end
            tta_pkg::CODE_DOWN:
            begin
                pred_led_up = 1'b0;
                pred_led_down = 1'b1;
                pred_mode = tta_pkg::CODE_DOWN;
            end
            default:
            begin
                pred_led_up = 1'b1;
                pred_led_down = 1'b1;
                pred_count = 0;
                pred_mode = tta_pkg::CODE_IDLE;
            end
        endcase
    endfunction

    function automatic void travel_tick(input logic [15:0] elapsed, input logic [31:0] now,
                                        input logic up, input logic down, input bit rising);
        logic [31:0] slot;
        bit          aborted;
        slot = now / BLINK_MS;
        if (rising)
            pred_led_up = ~slot[0];
        else
            pred_led_down = ~slot[0];
        pred_count = pred_count - int'(elapsed);
        // Down is only looked at when up did not abort.
        aborted = up_released(up);
        if (!aborted)
            aborted = down_released(down);
        if (aborted)
            enter_mode(tta_pkg::CODE_IDLE);
        else if (pred_count <= 0)
            enter_mode(rising ? tta_pkg::CODE_UP : tta_pkg::CODE_DOWN);
    endfunction

    function automatic tick_result_t actuator_step(input logic [15:0] elapsed,
                                                   input logic [31:0] now,
                                                   input logic up, input logic down);
        tick_result_t res;
        case (pred_mode)
            tta_pkg::CODE_RISING:   travel_tick(elapsed, now, up, down, 1'b1);
            tta_pkg::CODE_LOWERING: travel_tick(elapsed, now, up, down, 1'b0);
            tta_pkg::CODE_UP:
            begin
                if (down_released(down))
                    enter_mode(tta_pkg::CODE_LOWERING);
            end
            tta_pkg::CODE_DOWN:
            begin
                if (up_released(up))
                    enter_mode(tta_pkg::CODE_RISING);
            end
            default:
            begin
                if (up_released(up))
                    enter_mode(tta_pkg::CODE_RISING);
                else if (down_released(down))
                    enter_mode(tta_pkg::CODE_LOWERING);
            end
        endcase
        res.valve_up = (pred_mode == tta_pkg::CODE_RISING);
        res.valve_down = (pred_mode == tta_pkg::CODE_LOWERING);
        res.led_up = pred_led_up;
        res.led_down = pred_led_down;
        res.activity = pred_activity;
        res.mode = pred_mode;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_result
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ticks.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual mode %0d",
                         $time, mode_now);
                error_count++;
            end
            else
            begin
                want = pending_ticks.pop_front();
                check_field("valve_up", {2'b00, want.valve_up}, {2'b00, valve_up});
                check_field("valve_down", {2'b00, want.valve_down}, {2'b00, valve_down});
                check_field("led_up", {2'b00, want.led_up}, {2'b00, led_up});
                check_field("led_down", {2'b00, want.led_down}, {2'b00, led_down});
                check_field("activity_led", {2'b00, want.activity}, {2'b00, activity_led});
                check_field("mode_now", want.mode, mode_now);
            end
        end
    end

    // Receiver side: a long hold-off takes priority over the random stall runs.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end
        else if (stall_run > 0)
        begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end
        else if (stall_gaps_on && $urandom_range(0, 99) >= 70)
        begin
            out_stall <= 1'b1;
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                    : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 16'd0;
        else if (r < 6)
            return 16'hFFFF;
        else if (r < 14)
            return 16'($urandom_range(0, 65535));
        else
            return 16'($urandom_range(0, 800));
    endfunction

    // Valid stays high from one beat to the next unless a gap is taken.
    task automatic send_tick(input logic [15:0] elapsed, input logic [31:0] now,
                             input logic up, input logic down);
        int gap;
        gap = idle_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        elapsed_ms <= elapsed;
        now_ms <= now;
        up_held <= up;
        down_held <= down;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_ticks.push_back(actuator_step(elapsed, now, up, down));
        ticks_sent++;
    endtask

    task automatic timed_tick(input logic up, input logic down);
        logic [15:0] e;
        e = pick_elapsed();
        if ($urandom_range(0, 19) == 0)
            wall_ms = $urandom();
        else
            wall_ms = wall_ms + e;
        send_tick(e, wall_ms, up, down);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [19:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == tta_pkg::CFG_RAISE_TIME)
            pred_raise_ms = value;
        else
            pred_lower_ms = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
    endtask

    task automatic test_travel_cases();
        send_tick(16'd0, 32'd0, 1'b1, 1'b1);
        // Both released while idle: up wins and down is not sampled.
        send_tick(16'd10, 32'd399, 1'b0, 1'b0);
        send_tick(16'd1000, 32'd400, 1'b0, 1'b0);
        send_tick(16'd0, 32'd800, 1'b1, 1'b0);
        send_tick(16'd0, 32'd800, 1'b0, 1'b0);
        // Count lands exactly on zero.
        send_tick(16'd3000, 32'd1199, 1'b0, 1'b0);
        send_tick(16'd0, 32'd0, 1'b1, 1'b1);
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
        send_tick(16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_tick(16'hFFFF, 32'd0, 1'b1, 1'b0);
        send_tick(16'd0, 32'd0, 1'b0, 1'b1);
        send_tick(16'd500, 32'h8000_0000, 1'b1, 1'b1);
        send_tick(16'd500, 32'd400, 1'b0, 1'b1);
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
        send_tick(16'd1, 32'd0, 1'b1, 1'b0);
        send_tick(16'd1, 32'd0, 1'b0, 1'b0);
    endtask

    task automatic test_config_extremes();
        wait_drain();
        write_reg(tta_pkg::CFG_RAISE_TIME, 20'd0);
        write_reg(tta_pkg::CFG_LOWER_TIME, 20'hFFFFF);
        send_tick(16'd0, 32'd0, 1'b1, 1'b0);
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
        send_tick(16'd0, 32'd0, 1'b0, 1'b1);
        send_tick(16'd0, 32'd0, 1'b0, 1'b0);
        send_tick(16'hFFFF, 32'd400, 1'b0, 1'b0);
        send_tick(16'hFFFF, 32'd800, 1'b0, 1'b0);
        send_tick(16'd7, 32'd1600, 1'b1, 1'b1);
    endtask

    // Mostly press-and-release sequences so that travel starts, aborts and ends;
    // the rest are random button levels.
    task automatic run_button_traffic(input int count);
        int target;
        int hold;
        int rest;
        int k;
        bit pick_down;
        bit both;
        target = ticks_sent + count;
        while (ticks_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pick_down = 1'($urandom_range(0, 1));
                both = ($urandom_range(0, 5) == 0);
                hold = $urandom_range(1, 3);
                for (k = 0; k < hold; k++)
                    timed_tick(!pick_down || both, pick_down || both);
                if (both && $urandom_range(0, 1) == 1)
                    timed_tick(pick_down, !pick_down);
                else
                    timed_tick(1'b0, 1'b0);
                rest = $urandom_range(0, 8);
                for (k = 0; k < rest; k++)
                    timed_tick(1'b0, 1'b0);
            end
            else
            begin
                rest = $urandom_range(1, 3);
                for (k = 0; k < rest; k++)
                    timed_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random_traffic();
        int          ph;
        logic [19:0] raise_ms;
        logic [19:0] lower_ms;
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    raise_ms = tta_pkg::RAISE_TIME_RESET;
                    lower_ms = tta_pkg::LOWER_TIME_RESET;
                end
                1:
                begin
                    raise_ms = 20'd0;
                    lower_ms = 20'hFFFFF;
                end
                2:
                begin
                    raise_ms = 20'hFFFFF;
                    lower_ms = 20'd0;
                end
                3:
                begin
                    raise_ms = 20'($urandom_range(0, 4000));
                    lower_ms = 20'($urandom_range(0, 4000));
                end
                default:
                begin
                    raise_ms = 20'd1;
                    lower_ms = 20'd1;
                end
            endcase
            wait_drain();
            // One phase runs back to back with no idling on either side.
            idle_gaps_on = (ph != 3);
            stall_gaps_on = (ph != 3);
            write_reg(tta_pkg::CFG_RAISE_TIME, raise_ms);
            write_reg(tta_pkg::CFG_LOWER_TIME, lower_ms);
            run_button_traffic(90);
        end
        idle_gaps_on = 1'b1;
        stall_gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        int k;
        wait_drain();
        write_reg(tta_pkg::CFG_RAISE_TIME, 20'd1500);
        write_reg(tta_pkg::CFG_LOWER_TIME, 20'd2500);
        idle_gaps_on = 1'b0;
        // The receiver holds off long enough for the block to fill and stall its input.
        hold_off_left = 80;
        for (k = 0; k < 40; k++)
            timed_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        wait_drain();
        idle_gaps_on = 1'b1;
        run_button_traffic(12);
    endtask

    initial
    begin
        reset_prediction();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_travel_cases();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        wait_drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== timed_two_way_actuator_control.f =====
rtl/core/tta_pkg.sv
rtl/core/tta_blink.sv
rtl/core/timed_two_way_actuator_control.sv
test/tb_top.sv
